// ===== src/tcw_pkg.sv =====
// text console writer package: operation codes, control characters,
// sequencer state type and reset attribute. depends on nothing.
package tcw_pkg;

  // operation selector carried on the input tuser
  typedef enum logic [1:0] {
    F_PUT   = 2'd0,
    F_SET   = 2'd1,
    F_CLEAR = 2'd2,
    F_READ  = 2'd3
  } func_t;

  // control characters handled by put character
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_BLANK = 8'h00;

  localparam logic [7:0] RESET_ATTR = 8'h70;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXEC   = 9'b000000010,
    S_PUT    = 9'b000000100,
    S_BS     = 9'b000001000,
    S_RDWAIT = 9'b000010000,
    S_COPY   = 9'b000100000,
    S_DRAIN  = 9'b001000000,
    S_FILL   = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

endpackage

// ===== src/tcw_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/text_console_writer_top.sv =====
// text console writer top level: sequencer, cursor and colour registers,
// shared cell address unit. depends on tcw_pkg and tcw_ram.
//
// usage
//   input channel in_*: one beat is one operation, selected by in_tuser
//   (put character, set cursor and colour, clear screen, read cell).
//   output channel out_*: exactly one result beat per input beat, in order,
//   carrying the cursor, the current colour and, for a read, the cell.
// operation sequences
//   backspace / delete blank the cell in a further state, read cell waits for
//   the ram read data, tab writes spaces up to the next multiple of four (1..4).
//   clear screen blanks every cell and homes the cursor.
//   scroll (line feed or wrap on the last row): one copy
//   read per cycle through the single ram read port, then one blanking
//   write per cycle for the bottom row
//   in_tready is high only while the sequencer is idle.
// reset
//   rst_n is synchronous, active low. after release a clearing pass writes
//   every cell (char 0, attribute 0x70) with in_tready low.
// stalls
//   the result sits in an output register; a new beat is still accepted
//   while it waits. a further result waits in its own state until
//   out_tready frees the register.
module text_console_writer_top #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code, new_x, new_y, new_color, keep_x, keep_y, keep_color, zero pad
  input  logic [31:0] in_tdata,
  // func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_col, cursor_row, current_attr, cell_char, cell_attr, zero pad
  output logic [39:0] out_tdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(COLS);
  localparam int YW    = $clog2(ROWS);

  localparam logic [AW-1:0] COLS_A   = AW'(COLS);
  localparam logic [AW-1:0] LAST_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOTTOM_A = AW'((ROWS - 1) * COLS);
  localparam logic [XW-1:0] XMAX     = XW'(COLS - 1);
  localparam logic [YW-1:0] YMAX     = YW'(ROWS - 1);
  localparam logic [XW:0]   XWRAP    = (XW + 1)'(COLS);

  // sequencer and cursor state
  tcw_pkg::state_t state_r, state_nxt;
  logic            init_r, init_nxt;     // clearing pass after reset, no result
  logic [XW-1:0]   cur_x_r, cur_x_nxt;
  logic [YW-1:0]   cur_y_r, cur_y_nxt;
  logic [7:0]      color_r, color_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;       // copy read address or fill address
  logic            pend_r, pend_nxt;     // copy write waiting for read data
  logic [AW-1:0]   wa_r, wa_nxt;
  logic [15:0]     cell_r, cell_nxt;     // {attr, char} returned by a read

  // captured operation
  tcw_pkg::func_t  func_r;
  logic [7:0]      ch_r;
  logic [6:0]      nx_r;
  logic [4:0]      ny_r;
  logic [7:0]      ncol_r;
  logic            kx_r, ky_r, kc_r;

  // output register
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [39:0]     out_data_r, out_data_nxt;

  logic            in_fire;
  logic            slot_free;
  logic            finish;
  logic            do_put;

  // ram port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  // decode of the captured character
  logic            is_tab, is_bs, is_lf, is_cr;
  logic [7:0]      put_ch;

  // saturated position for set cursor and read cell
  logic [XW-1:0]   sat_x;
  logic [YW-1:0]   sat_y;

  // shared cell address unit: row times COLS plus column
  logic [XW-1:0]   ax;
  logic [YW-1:0]   ay;
  logic [AW-1:0]   cell_addr;

  logic [XW:0]     x_inc;
  logic            wrap;

  logic [6:0]      col_w;
  logic [4:0]      row_w;

  assign in_tready = (state_r == tcw_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  assign is_tab = (ch_r == tcw_pkg::CH_TAB);
  assign is_bs  = (ch_r == tcw_pkg::CH_BS) || (ch_r == tcw_pkg::CH_DEL);
  assign is_lf  = (ch_r == tcw_pkg::CH_LF);
  assign is_cr  = (ch_r == tcw_pkg::CH_CR);
  assign put_ch = is_tab ? tcw_pkg::CH_SPACE : ch_r;

  assign sat_x = (int'(nx_r) > COLS - 1) ? XMAX : XW'(nx_r);
  assign sat_y = (int'(ny_r) > ROWS - 1) ? YMAX : YW'(ny_r);

  // reads take the requested cell, everything else the cursor cell
  always_comb begin
    if ((state_r == tcw_pkg::S_EXEC) && (func_r == tcw_pkg::F_READ)) begin
      ax = sat_x;
      ay = sat_y;
    end else begin
      ax = cur_x_r;
      ay = cur_y_r;
    end
  end

  assign cell_addr = AW'(ay) * COLS_A + AW'(ax);

  assign x_inc = {1'b0, cur_x_r} + (XW + 1)'(1);
  assign wrap  = (x_inc == XWRAP);

  // plain write of a character at the cursor, every tab space included
  assign do_put = (state_r == tcw_pkg::S_PUT) ||
                  ((state_r == tcw_pkg::S_EXEC) && (func_r == tcw_pkg::F_PUT) &&
                   !is_bs && !is_cr && !is_lf);

  // ram write port: pending copy first, then fill, then cursor writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = {color_r, tcw_pkg::CH_BLANK};
    priority if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = wa_r;
      ram_wdata = ram_rdata;
    end else if (state_r == tcw_pkg::S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r;
      ram_wdata = {color_r, tcw_pkg::CH_BLANK};
    end else if (do_put) begin
      ram_we    = 1'b1;
      ram_wdata = {color_r, put_ch};
    end else if (state_r == tcw_pkg::S_BS) begin
      ram_we    = 1'b1;
      ram_wdata = {color_r, tcw_pkg::CH_SPACE};
    end else begin
      ram_we    = 1'b0;
    end
  end

  assign ram_raddr = (state_r == tcw_pkg::S_COPY) ? cnt_r : cell_addr;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    color_nxt = color_r;
    cnt_nxt   = cnt_r;
    cell_nxt  = cell_r;
    finish    = 1'b0;
    pend_nxt  = (state_r == tcw_pkg::S_COPY);
    wa_nxt    = cnt_r - COLS_A;

    unique case (state_r)
      tcw_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = tcw_pkg::S_EXEC;
        end
      end
      tcw_pkg::S_EXEC: begin
        cell_nxt = 16'h0000;
        unique case (func_r)
          tcw_pkg::F_PUT: begin
            if (is_bs) begin
              if (cur_x_r != '0) begin
                cur_x_nxt = cur_x_r - XW'(1);
              end
              state_nxt = tcw_pkg::S_BS;
            end else if (is_cr) begin
              cur_x_nxt = '0;
              finish    = 1'b1;
            end else if (is_lf) begin
              if (cur_y_r == YMAX) begin
                cnt_nxt   = COLS_A;
                state_nxt = tcw_pkg::S_COPY;
              end else begin
                cur_y_nxt = cur_y_r + YW'(1);
                finish    = 1'b1;
              end
            end
          end
          tcw_pkg::F_SET: begin
            if (!kx_r) cur_x_nxt = sat_x;
            if (!ky_r) cur_y_nxt = sat_y;
            if (!kc_r) color_nxt = ncol_r;
            finish = 1'b1;
          end
          tcw_pkg::F_CLEAR: begin
            cur_x_nxt = '0;
            cur_y_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = tcw_pkg::S_FILL;
          end
          tcw_pkg::F_READ: begin
            state_nxt = tcw_pkg::S_RDWAIT;
          end
        endcase
      end
      tcw_pkg::S_PUT: begin
      end
      tcw_pkg::S_BS: begin
        finish = 1'b1;
      end
      tcw_pkg::S_RDWAIT: begin
        cell_nxt = ram_rdata;
        finish   = 1'b1;
      end
      tcw_pkg::S_COPY: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_A) begin
          state_nxt = tcw_pkg::S_DRAIN;
        end
      end
      tcw_pkg::S_DRAIN: begin
        // last copy write lands this cycle, then blank the bottom row
        cnt_nxt   = BOTTOM_A;
        state_nxt = tcw_pkg::S_FILL;
      end
      tcw_pkg::S_FILL: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_A) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = tcw_pkg::S_IDLE;
          end else begin
            finish = 1'b1;
          end
        end
      end
      tcw_pkg::S_RESP: begin
        finish = 1'b1;
      end
      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase

    // cursor advance after a plain write, with wrap, scroll and tab stops
    if (do_put) begin
      if (wrap) begin
        cur_x_nxt = '0;
        if (cur_y_r == YMAX) begin
          cnt_nxt   = COLS_A;
          state_nxt = tcw_pkg::S_COPY;
        end else begin
          cur_y_nxt = cur_y_r + YW'(1);
          finish    = 1'b1;
        end
      end else begin
        cur_x_nxt = x_inc[XW-1:0];
        if (is_tab && (x_inc[1:0] != 2'b00)) begin
          state_nxt = tcw_pkg::S_PUT;
        end else begin
          finish = 1'b1;
        end
      end
    end

    if (finish) begin
      state_nxt = slot_free ? tcw_pkg::S_IDLE : tcw_pkg::S_RESP;
    end
  end

  // result beat assembly
  assign col_w = 7'(cur_x_nxt);
  assign row_w = 5'(cur_y_nxt);

  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_data_nxt   = out_data_r;
    if (finish && slot_free) begin
      out_tvalid_nxt = 1'b1;
      out_data_nxt   = {4'b0000, cell_nxt[15:8], cell_nxt[7:0], color_nxt,
                        row_w, col_w};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcw_pkg::S_FILL;
      init_r       <= 1'b1;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      color_r      <= tcw_pkg::RESET_ATTR;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      color_r      <= color_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wa_r       <= wa_nxt;
    cell_r     <= cell_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      func_r <= tcw_pkg::func_t'(in_tuser);
      ch_r   <= in_tdata[7:0];
      nx_r   <= in_tdata[14:8];
      ny_r   <= in_tdata[19:15];
      ncol_r <= in_tdata[27:20];
      kx_r   <= in_tdata[28];
      ky_r   <= in_tdata[29];
      kc_r   <= in_tdata[30];
    end
  end

endmodule

// ===== src/tcw_checker.sv =====
// port-level checker for the text console writer and its bind
// depends on text_console_writer_top
module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // one operation at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an operation is in progress");

  // reset starts the clearing pass with no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block ready or result shown during clearing pass");

  // reported cursor row stays on the screen
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[11:7]) < ROWS))
    else $error("cursor row beyond last row");

  // reported cursor column stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[6:0]) < COLS))
    else $error("cursor column beyond last column");

endmodule

bind text_console_writer_top tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (.*);

// ===== sim/text_console_writer_checker.sv =====
// checker for the text console writer: watches both stream channels, keeps its own
// copy of the screen, cursor and colour, and compares every result beat.
// depends on tcw_pkg.
`timescale 1ns / 1ps

module text_console_writer_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          waiting,
  output int          matched,
  output int          scrolls
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;

  // result fields, last field in the lowest bits
  typedef struct packed {
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
    logic [7:0] current_attr;
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
  } status_t;

  logic [7:0]  glyph [CELLS];
  logic [7:0]  tint  [CELLS];
  int unsigned col_q;
  int unsigned row_q;
  logic [7:0]  ink;
  status_t     due_q [$];
  int          errs;
  int          seen;
  int          scroll_cnt;

  function automatic int unsigned saturate(input int unsigned v, input int unsigned lim);
    return (v > lim - 1) ? lim - 1 : v;
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      glyph[i] = CH_BLANK;
      tint[i]  = ink;
    end
    col_q = 0;
    row_q = 0;
  endfunction

  function automatic void line_down();
    row_q++;
    if (row_q >= ROWS) begin
      for (int i = 0; i < CELLS - COLS; i++) begin
        glyph[i] = glyph[i + COLS];
        tint[i]  = tint[i + COLS];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
        glyph[i] = CH_BLANK;
        tint[i]  = ink;
      end
      scroll_cnt++;
      row_q = ROWS - 1;
    end
  endfunction

  function automatic void write_cell(input logic [7:0] ch);
    glyph[row_q * COLS + col_q] = ch;
    tint[row_q * COLS + col_q]  = ink;
  endfunction

  function automatic void put_plain(input logic [7:0] ch);
    write_cell(ch);
    col_q++;
    if (col_q >= COLS) begin
      col_q = 0;
      line_down();
    end
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    if (ch == CH_TAB) begin
      do put_plain(CH_SPACE); while (col_q % 4 != 0);
    end else if (ch == CH_BS || ch == CH_DEL) begin
      if (col_q > 0) col_q--;
      write_cell(CH_SPACE);
    end else if (ch == CH_CR) begin
      col_q = 0;
    end else if (ch == CH_LF) begin
      line_down();
    end else begin
      put_plain(ch);
    end
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    status_t     exp_s;
    status_t     got_s;
    logic [31:0] d;
    int unsigned rx;
    int unsigned ry;
    if (!rst_n) begin
      ink = RESET_ATTR;
      blank_screen();
      due_q.delete();
      errs       = 0;
      seen       = 0;
      scroll_cnt = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_s = out_tdata[35:0];
        if (due_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, got %h",
                   $time, got_s);
          errs++;
        end else begin
          exp_s = due_q.pop_front();
          check_field("cursor_col", 8'(exp_s.cursor_col), 8'(got_s.cursor_col));
          check_field("cursor_row", 8'(exp_s.cursor_row), 8'(got_s.cursor_row));
          check_field("current_attr", exp_s.current_attr, got_s.current_attr);
          check_field("cell_char", exp_s.cell_char, got_s.cell_char);
          check_field("cell_attr", exp_s.cell_attr, got_s.cell_attr);
          seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        d     = in_tdata;
        exp_s = '0;
        case (func_t'(in_tuser))
          F_PUT: put_char(d[7:0]);
          F_SET: begin
            if (!d[28]) col_q = saturate(d[14:8], COLS);
            if (!d[29]) row_q = saturate(d[19:15], ROWS);
            if (!d[30]) ink = d[27:20];
          end
          F_CLEAR: blank_screen();
          default: begin
            rx = saturate(d[14:8], COLS);
            ry = saturate(d[19:15], ROWS);
            exp_s.cell_char = glyph[ry * COLS + rx];
            exp_s.cell_attr = tint[ry * COLS + rx];
          end
        endcase
        exp_s.cursor_col   = col_q[6:0];
        exp_s.cursor_row   = row_q[4:0];
        exp_s.current_attr = ink;
        due_q.push_back(exp_s);
      end
    end
    fail_count <= errs;
    waiting    <= due_q.size();
    matched    <= seen;
    scrolls    <= scroll_cnt;
  end

endmodule

// ===== sim/text_console_writer_top_tb.sv =====
// testbench top for the text console writer: clock, reset, operation stimulus and
// result back-pressure, verdict. depends on tcw_pkg, text_console_writer_top and
// text_console_writer_checker.
`timescale 1ns / 1ps

module text_console_writer_top_tb;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // char_code, new_x, new_y, new_color, keep_x, keep_y, keep_color, zero pad
  logic [31:0] in_tdata   = '0;
  // func
  logic [1:0]  in_tuser   = F_PUT;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // cursor_col, cursor_row, current_attr, cell_char, cell_attr, zero pad
  logic [39:0] out_tdata;

  int fail_count;
  int waiting;
  int matched;
  int scrolls;

  int sent;
  int per_func [4];
  bit calm;      // no input gaps while set
  bit out_calm;  // no output stalls while set

  text_console_writer_top #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  text_console_writer_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) CHK (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .waiting    (waiting),
    .matched    (matched),
    .scrolls    (scrolls)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond a run where every beat scrolls and every stall is long
  initial begin
    #40_000_000;
    $display("text_console_writer_top test failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 60);
  endfunction

  // positions mostly on screen, sometimes anywhere in the field to hit saturation
  function automatic logic [6:0] pick_col();
    return ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, COLS - 1)) : 7'($urandom);
  endfunction

  function automatic logic [4:0] pick_row();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, ROWS - 1)) : 5'($urandom);
  endfunction

  // one operation beat; keeps is {keep_color, keep_y, keep_x}
  task automatic send_op(input func_t f, input logic [7:0] ch, input logic [6:0] x,
                         input logic [4:0] y, input logic [7:0] col,
                         input logic [2:0] keeps);
    int gap;
    in_tuser  <= f;
    in_tdata  <= {1'b0, keeps, col, y, x, ch};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
    per_func[f]++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result back-pressure: random stalls, with stretches of none
  initial begin
    forever begin
      @(posedge clk);
      if (!out_calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end
      out_tready <= 1'b1;
      if ($urandom_range(0, 199) == 0) out_calm = ~out_calm;
    end
  end

  initial begin
    logic [6:0] x0;
    logic [4:0] y0;
    int         len;
    int         drain;
    logic [7:0] ch;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    // read straight after the clearing pass, then a saturated read
    send_op(F_READ, 8'h00, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_READ, 8'hff, 7'h7f, 5'h1f, 8'hff, 3'b111);
    // bottom right corner, full colour, then wrap and scroll
    send_op(F_SET, 8'h00, 7'(COLS - 1), 5'(ROWS - 1), 8'hff, 3'b000);
    send_op(F_PUT, 8'h41, 7'h7f, 5'h1f, 8'h00, 3'b111);
    send_op(F_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 2), 8'h00, 3'b000);
    send_op(F_READ, 8'h00, 7'd0, 5'(ROWS - 1), 8'h00, 3'b000);
    // set with every keep flag high leaves all alone
    send_op(F_SET, 8'h00, 7'd5, 5'd5, 8'h00, 3'b111);
    // tab from column three writes one space, from column four writes four
    send_op(F_SET, 8'h00, 7'd3, 5'd2, 8'h00, 3'b100);
    send_op(F_PUT, CH_TAB, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, CH_TAB, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, CH_BS, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, CH_DEL, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, CH_CR, 7'd0, 5'd0, 8'h00, 3'b000);
    // delete at column zero stays put
    send_op(F_PUT, CH_DEL, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, CH_LF, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, 8'hff, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_PUT, 8'h00, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_READ, 8'h00, 7'd0, 5'd3, 8'h00, 3'b000);
    // row beyond the screen saturates, line feed on the last row scrolls
    send_op(F_SET, 8'h00, 7'd40, 5'h1f, 8'h00, 3'b000);
    send_op(F_PUT, CH_LF, 7'd0, 5'd0, 8'h00, 3'b000);
    // tab across the line end wraps
    send_op(F_SET, 8'h00, 7'(COLS - 2), 5'd10, 8'h00, 3'b100);
    send_op(F_PUT, CH_TAB, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_CLEAR, 8'hff, 7'h7f, 5'h1f, 8'hff, 3'b111);
    send_op(F_READ, 8'h00, 7'd0, 5'd0, 8'h00, 3'b000);
    send_op(F_READ, 8'h00, 7'(COLS - 1), 5'(ROWS - 1), 8'h00, 3'b000);

    // random part, built from runs of related operations
    while (sent < 900) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      case ($urandom_range(0, 99)) inside
        [0:44]: begin
          // text written at a known spot, then some of it read back
          x0  = 7'($urandom_range(0, COLS - 1));
          y0  = 5'($urandom_range(0, ROWS - 1));
          len = $urandom_range(1, 30);
          send_op(F_SET, 8'($urandom), x0, y0, 8'($urandom), {1'($urandom), 2'b00});
          repeat (len) begin
            ch = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(32, 126)) : 8'($urandom);
            send_op(F_PUT, ch, 7'($urandom), 5'($urandom), 8'($urandom), 3'($urandom));
          end
          repeat ($urandom_range(1, 3))
            send_op(F_READ, 8'($urandom), 7'(x0 + $urandom_range(0, len - 1)), y0,
                    8'($urandom), 3'($urandom));
        end
        [45:59]: begin
          // control characters mixed with the odd plain one
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
              0:       ch = CH_BS;
              1:       ch = CH_DEL;
              2:       ch = CH_TAB;
              3:       ch = CH_CR;
              4:       ch = CH_LF;
              default: ch = 8'($urandom);
            endcase
            send_op(F_PUT, ch, 7'($urandom), 5'($urandom), 8'($urandom), 3'($urandom));
          end
        end
        [60:74]: begin
          repeat ($urandom_range(1, 6))
            send_op(F_READ, 8'($urandom), pick_col(), pick_row(), 8'($urandom),
                    3'($urandom));
        end
        [75:86]: begin
          send_op(F_SET, 8'($urandom), pick_col(), pick_row(), 8'($urandom),
                  3'($urandom));
        end
        [87:89]: begin
          send_op(F_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 8'($urandom),
                  3'($urandom));
        end
        [90:94]: begin
          // drive the cursor onto the last row and push it off
          send_op(F_SET, 8'($urandom), 7'($urandom_range(COLS - 6, COLS - 1)),
                  5'(ROWS - 1), 8'($urandom), {1'($urandom), 2'b00});
          repeat ($urandom_range(1, 3)) begin
            ch = $urandom_range(0, 1) ? CH_LF : 8'($urandom_range(32, 126));
            send_op(F_PUT, ch, 7'($urandom), 5'($urandom), 8'($urandom), 3'($urandom));
          end
          send_op(F_READ, 8'($urandom), pick_col(), 5'(ROWS - 2), 8'($urandom),
                  3'($urandom));
        end
        default: begin
          // noise: any operation, every field random
          repeat ($urandom_range(1, 5))
            send_op(func_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
                    5'($urandom), 8'($urandom), 3'($urandom));
        end
      endcase
    end
    in_tvalid <= 1'b0;

    // let the last result arrive, then sit out a full scroll for strays
    @(posedge clk);
    drain = 0;
    while (waiting != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    if (drain >= 200000) begin
      $display("text_console_writer_top test failed");
      $finish;
    end else begin
      repeat (COLS * ROWS + 100) @(posedge clk);
      $display("run covered %0d beats: %0d put, %0d set, %0d clear, %0d read",
               sent, per_func[F_PUT], per_func[F_SET], per_func[F_CLEAR], per_func[F_READ]);
      $display("%0d results compared, %0d screen scrolls predicted", matched, scrolls);
      if (fail_count == 0 && waiting == 0) begin
        $display("text_console_writer_top test passed");
      end else begin
        $display("text_console_writer_top test failed");
      end
      $finish;
    end
  end

endmodule
